// ----- design/odg_pkg.sv -----
// ----------------------------------------------------------------------------
// odg_pkg: shared types and constants for the obstacle distance grid
// Payload structs, item kinds, cell classes and the front-to-back command.
// ----------------------------------------------------------------------------
`default_nettype none
package odg_pkg;

    localparam int unsigned COORD_W    = 6;
    localparam int unsigned DIST_W     = 8;
    localparam int unsigned CLASS_W    = 2;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned GREEN_W    = 8;
    localparam logic [DIST_W-1:0] RADIUS_CAP = 8'd128;
    localparam logic [DIST_W-1:0] RADIUS_RST = 8'd64;

    localparam logic [1:0] ADDR_MAX_RADIUS = 2'd0;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [CLASS_W-1:0] CLS_FREE    = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_OCC     = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [GREEN_W-1:0] green_level;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0]  obstacle_distance;
        logic [CLASS_W-1:0] cell_class;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_QUERY,
        OP_QUERY_OUT,
        OP_MARK_OCC,
        OP_MARK_FREE,
        OP_MARK_UNK
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
    } t_cmd;

endpackage
`default_nettype wire

// ----- design/obstacle_distance_grid.sv -----
// ----------------------------------------------------------------------------
// obstacle_distance_grid: occupancy grid with capped obstacle distances
// Classifier front end, command queue and grid engine with two memories.
// ----------------------------------------------------------------------------
// A clear sweeps every cell (GRID_W*GRID_H), and an occupied load visits each
// of the up to (2*MAX_REACH+1)^2 window cells, running the serial square-root
// unit on each offset's Q4.4 distance. After reset the grid engine sweeps
// every cell before it takes a command; the front end still queues items
// meanwhile.
`default_nettype none
module obstacle_distance_grid #(
    parameter int unsigned GRID_W    = 64,
    parameter int unsigned GRID_H    = 64,
    parameter int unsigned MAX_REACH = 8,
    parameter int unsigned PIXEL_MAX = 255
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  odg_pkg::t_in_item         i_item,
    output logic                      o_valid,
    input  wire                       i_ready,
    output odg_pkg::t_out_item        o_item,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire [1:0]                 paddr,
    input  wire [31:0]                pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import odg_pkg::*;

    logic [DIST_W-1:0] r_radius;
    logic              w_fv, w_fr, w_qv, w_qr;
    t_cmd              w_fc, w_qc;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_RADIUS) ? {24'd0, r_radius} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (psel && penable && pwrite && paddr == ADDR_MAX_RADIUS) begin
            r_radius <= pwdata[DIST_W-1:0];
        end
    end

    odg_front #(.GRID_W(GRID_W), .GRID_H(GRID_H), .PIXEL_MAX(PIXEL_MAX)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_cmd_valid(w_fv), .i_cmd_ready(w_fr), .o_cmd(w_fc)
    );

    odg_queue #(.DEPTH(4)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_ready(w_fr),
        .i_cmd(w_fc), .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_qc)
    );

    odg_back #(.GRID_W(GRID_W), .GRID_H(GRID_H), .MAX_REACH(MAX_REACH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_radius(r_radius),
        .i_cmd_valid(w_qv), .o_cmd_ready(w_qr), .i_cmd(w_qc),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

endmodule
`default_nettype wire

// ----- design/odg_front.sv -----
// ----------------------------------------------------------------------------
// odg_front: item classifier
// Takes input items, classifies the pixel and pushes at most one command per item
// ----------------------------------------------------------------------------
`default_nettype none
module odg_front #(
    parameter int unsigned GRID_W    = 64,
    parameter int unsigned GRID_H    = 64,
    parameter int unsigned PIXEL_MAX = 255
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  odg_pkg::t_in_item    i_item,
    output logic                 o_cmd_valid,
    input  wire                  i_cmd_ready,
    output odg_pkg::t_cmd        o_cmd
);
    import odg_pkg::*;

    // Thresholds on green: occ = 100 - floor(100 g / PMAX).
    // occ > 90 <=> floor(100g/P) < 10 <=> 100g < 10P
    // occ < 10 <=> floor(100g/P) > 90 <=> 100g >= 91P
    localparam int unsigned PROD_W = GREEN_W + 7;
    localparam int unsigned LIM_W  = 24;
    localparam logic [LIM_W-1:0] OCC_LIM  = LIM_W'(10 * PIXEL_MAX);
    localparam logic [LIM_W-1:0] FREE_LIM = LIM_W'(91 * PIXEL_MAX);

    logic               r_valid;
    t_cmd               r_cmd;
    logic [LIM_W-1:0]   w_prod;
    logic               w_inside;
    logic               w_take;
    t_cmd               w_cmd;
    logic               w_emit;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
    assign w_take      = i_valid && o_ready;
    assign w_prod      = LIM_W'({{(PROD_W-GREEN_W){1'b0}}, i_item.green_level}
                         * PROD_W'(100));
    assign w_inside    = (32'(i_item.cell_x) < GRID_W) && (32'(i_item.cell_y) < GRID_H);

    always_comb begin
        w_cmd.cell_x = i_item.cell_x;
        w_cmd.cell_y = i_item.cell_y;
        w_cmd.op     = OP_CLEAR;
        w_emit       = 1'b0;
        case (i_item.kind)
            KIND_CLEAR: begin
                w_emit = 1'b1;
            end
            KIND_QUERY: begin
                w_emit    = 1'b1;
                w_cmd.op  = w_inside ? OP_QUERY : OP_QUERY_OUT;
            end
            KIND_LOAD: begin
                w_emit = w_inside;
                if (w_prod < OCC_LIM) begin
                    w_cmd.op = OP_MARK_OCC;
                end else if (w_prod >= FREE_LIM) begin
                    w_cmd.op = OP_MARK_FREE;
                end else begin
                    w_cmd.op = OP_MARK_UNK;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= w_take && w_emit;
        end
        if (w_take) begin
            r_cmd <= w_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- design/odg_queue.sv -----
// ----------------------------------------------------------------------------
// odg_queue: command queue
// Short FIFO between the classifier and the grid engine.
// ----------------------------------------------------------------------------
`default_nettype none
module odg_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  odg_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  wire            i_ready,
    output odg_pkg::t_cmd  o_cmd
);
    import odg_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [AW:0]     r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- design/odg_back.sv -----
// ----------------------------------------------------------------------------
// odg_back: grid engine
// Holds the class and distance memories, runs clears, cell marks, dilation
// windows and queries.
// ----------------------------------------------------------------------------
`default_nettype none
module odg_back #(
    parameter int unsigned GRID_W    = 64,
    parameter int unsigned GRID_H    = 64,
    parameter int unsigned MAX_REACH = 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire [odg_pkg::DIST_W-1:0]     i_radius,
    input  wire                           i_cmd_valid,
    output logic                          o_cmd_ready,
    input  odg_pkg::t_cmd                 i_cmd,
    output logic                          o_valid,
    input  wire                           i_ready,
    output odg_pkg::t_out_item            o_item
);
    import odg_pkg::*;

    localparam int unsigned CELLS = GRID_W * GRID_H;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned XW    = $clog2(GRID_W) + 1;
    localparam int unsigned YW    = $clog2(GRID_H) + 1;
    localparam int unsigned OW    = $clog2(MAX_REACH + 1) + 1;
    localparam int unsigned NW    = 2 * OW + 1;

    typedef enum logic [3:0] {
        ST_RESET, ST_IDLE, ST_CLEAR, ST_QRD, ST_QOUT, ST_WIN_RD, ST_WIN_WAIT,
        ST_WIN_WR, ST_ISQ, ST_OUT
    } t_state;

    t_state                r_state;
    logic [AW:0]           r_clr;
    logic [DIST_W-1:0]     r_clr_val;
    logic [DIST_W-1:0]     r_dist_mem [CELLS];
    logic [CLASS_W-1:0]    r_cls_mem  [CELLS];
    logic [DIST_W-1:0]     r_rd_dist;
    logic [CLASS_W-1:0]    r_rd_cls;
    logic [COORD_W-1:0]    r_cx;
    logic [COORD_W-1:0]    r_cy;
    logic signed [OW-1:0]  r_di;
    logic signed [OW-1:0]  r_dj;
    logic signed [OW-1:0]  r_dn;
    logic [AW-1:0]         r_addr;
    logic                  r_in_grid;
    logic [DIST_W-1:0]     r_off_d;
    logic [NW+10:0]        r_lim;
    logic [DIST_W-1:0]     r_q;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic signed [XW:0]    w_nx;
    logic signed [YW:0]    w_ny;
    logic [NW-1:0]         w_n;
    logic [DIST_W:0]       w_t;
    logic [2*DIST_W+1:0]   w_tsq;
    logic [DIST_W-1:0]     w_reach;
    logic                  w_last;

    assign o_valid     = r_out_valid;
    assign o_item      = r_out;
    assign o_cmd_ready = (r_state == ST_IDLE) && !r_out_valid;

    assign w_nx  = (XW+1)'(signed'({1'b0, r_cx})) + (XW+1)'(r_di);
    assign w_ny  = (YW+1)'(signed'({1'b0, r_cy})) + (YW+1)'(r_dj);
    assign w_n   = NW'(r_di * r_di) + NW'(r_dj * r_dj);
    assign w_t   = {r_q, 1'b1};
    assign w_tsq = (2*DIST_W+2)'(w_t) * (2*DIST_W+2)'(w_t);
    assign w_reach = (((i_radius > RADIUS_CAP) ? RADIUS_CAP : i_radius) + 8'd15) >> 4;
    assign w_last  = (r_di == r_dn) && (r_dj == r_dn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RESET;
            r_clr       <= '0;
            r_clr_val   <= RADIUS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_RESET, ST_CLEAR: begin
                    // sweep one cell a cycle
                    r_dist_mem[r_clr[AW-1:0]] <= r_clr_val;
                    r_cls_mem[r_clr[AW-1:0]]  <= CLS_UNKNOWN;
                    if (32'(r_clr) == CELLS - 1) begin
                        r_state <= ST_IDLE;
                    end
                    r_clr <= r_clr + 1'b1;
                end
                ST_IDLE: begin
                    r_cx   <= i_cmd.cell_x;
                    r_cy   <= i_cmd.cell_y;
                    r_addr <= AW'(32'(i_cmd.cell_y) * GRID_W + 32'(i_cmd.cell_x));
                    if (i_cmd_valid && o_cmd_ready) begin
                        case (i_cmd.op)
                            OP_CLEAR: begin
                                r_clr     <= '0;
                                r_clr_val <= (i_radius > RADIUS_CAP) ? RADIUS_CAP
                                                                     : i_radius;
                                r_state   <= ST_CLEAR;
                            end
                            OP_QUERY:     r_state <= ST_QRD;
                            OP_QUERY_OUT: r_state <= ST_QOUT;
                            OP_MARK_OCC: begin
                                r_cls_mem[AW'(32'(i_cmd.cell_y) * GRID_W
                                    + 32'(i_cmd.cell_x))] <= CLS_OCC;
                                r_dist_mem[AW'(32'(i_cmd.cell_y) * GRID_W
                                    + 32'(i_cmd.cell_x))] <= '0;
                                r_dn <= (32'(w_reach) > MAX_REACH) ? OW'(MAX_REACH)
                                                                    : OW'(w_reach);
                                r_di <= (32'(w_reach) > MAX_REACH) ? -OW'(MAX_REACH)
                                                                    : -OW'(w_reach);
                                r_dj <= (32'(w_reach) > MAX_REACH) ? -OW'(MAX_REACH)
                                                                    : -OW'(w_reach);
                                r_state <= (w_reach == '0) ? ST_IDLE : ST_WIN_RD;
                            end
                            OP_MARK_FREE: begin
                                r_cls_mem[AW'(32'(i_cmd.cell_y) * GRID_W
                                    + 32'(i_cmd.cell_x))] <= CLS_FREE;
                            end
                            OP_MARK_UNK: begin
                                r_cls_mem[AW'(32'(i_cmd.cell_y) * GRID_W
                                    + 32'(i_cmd.cell_x))] <= CLS_UNKNOWN;
                                r_dist_mem[AW'(32'(i_cmd.cell_y) * GRID_W
                                    + 32'(i_cmd.cell_x))] <= '0;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_QRD: begin
                    r_rd_dist <= r_dist_mem[r_addr];
                    r_rd_cls  <= r_cls_mem[r_addr];
                    r_state   <= ST_OUT;
                end
                ST_OUT: begin
                    r_out.obstacle_distance <= r_rd_dist;
                    r_out.cell_class        <= r_rd_cls;
                    r_out_valid             <= 1'b1;
                    r_state                 <= ST_IDLE;
                end
                ST_QOUT: begin
                    r_out.obstacle_distance <= '0;
                    r_out.cell_class        <= CLS_UNKNOWN;
                    r_out_valid             <= 1'b1;
                    r_state                 <= ST_IDLE;
                end
                ST_WIN_RD: begin
                    r_in_grid <= (w_nx >= 0) && (w_ny >= 0)
                              && (32'(w_nx) < GRID_W) && (32'(w_ny) < GRID_H);
                    r_addr    <= AW'(32'(w_ny) * GRID_W + 32'(w_nx));
                    r_lim     <= (NW+11)'(w_n) << 10;
                    r_q       <= '0;
                    r_state   <= ST_ISQ;
                end
                ST_ISQ: begin
                    // round(16 sqrt(n)): step q while (2q+1)^2 <= 1024 n
                    if (w_tsq <= (2*DIST_W+2)'(r_lim) && r_q != 8'hFF) begin
                        r_q <= r_q + 1'b1;
                    end else begin
                        r_off_d   <= r_q;
                        r_rd_dist <= r_dist_mem[r_addr];
                        r_state   <= ST_WIN_WAIT;
                    end
                end
                ST_WIN_WAIT: begin
                    r_state <= ST_WIN_WR;
                end
                ST_WIN_WR: begin
                    if (r_in_grid && (r_off_d < r_rd_dist)) begin
                        r_dist_mem[r_addr] <= r_off_d;
                    end
                    if (w_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        if (r_di == r_dn) begin
                            r_di <= -r_dn;
                            r_dj <= r_dj + 1'b1;
                        end else begin
                            r_di <= r_di + 1'b1;
                        end
                        r_state <= ST_WIN_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- dv/obstacle_distance_grid_tb.sv -----
// ----------------------------------------------------------------------------
// obstacle_distance_grid_tb: self-checking bench for the obstacle distance grid
// Drives load, query and clear transactions under several radius settings and
// checks every query result against a cell-level model of the grid.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module obstacle_distance_grid_tb;
    import odg_pkg::*;

    localparam int GRID_N    = 4096;
    localparam int REACH_MAX = 8;
    localparam int STALL_LIM = 300000;
    localparam int ITEMS_PER_PHASE = 235;

    // Grid model and in-order store of expected query results
    class grid_scoreboard;
        logic [DIST_W-1:0]  dist_q4 [GRID_N];
        logic [CLASS_W-1:0] cls [GRID_N];
        int unsigned        radius;
        t_out_item          due_results[$];
        int                 errors;
        int                 n_loads, n_queries, n_clears, n_checked;

        function new();
            radius = 32'(RADIUS_RST);
            clear_grid();
        endfunction

        function int unsigned eff_radius();
            return (radius > RADIUS_CAP) ? RADIUS_CAP : radius;
        endfunction

        function int reach();
            int r;
            r = (eff_radius() + 15) / 16;
            return (r > REACH_MAX) ? REACH_MAX : r;
        endfunction

        function void clear_grid();
            for (int k = 0; k < GRID_N; k++) begin
                dist_q4[k] = DIST_W'(eff_radius());
                cls[k] = CLS_UNKNOWN;
            end
        endfunction

        // 16*sqrt(n) rounded: largest q with (2q-1)^2 <= 1024n
        function int unsigned root_q4(int unsigned n);
            int unsigned q;
            q = 0;
            while ((2 * (q + 1) - 1) * (2 * (q + 1) - 1) <= 1024 * n)
                q++;
            return q;
        endfunction

        function void note_item(t_in_item it);
            int idx, occ, dn, nx, ny;
            int unsigned d;
            t_out_item res;
            idx = int'(it.cell_y) * 64 + int'(it.cell_x);
            case (it.kind)
                KIND_CLEAR: begin
                    n_clears++;
                    clear_grid();
                end
                KIND_QUERY: begin
                    n_queries++;
                    res.obstacle_distance = dist_q4[idx];
                    res.cell_class = cls[idx];
                    due_results.push_back(res);
                end
                KIND_LOAD: begin
                    n_loads++;
                    occ = 100 - (100 * int'(it.green_level)) / 255;
                    if (occ > 90) begin
                        cls[idx] = CLS_OCC;
                        dist_q4[idx] = '0;
                        dn = reach();
                        for (int dj = -dn; dj <= dn; dj++) begin
                            for (int di = -dn; di <= dn; di++) begin
                                nx = int'(it.cell_x) + di;
                                ny = int'(it.cell_y) + dj;
                                if (nx >= 0 && ny >= 0 && nx < 64 && ny < 64) begin
                                    d = root_q4(di * di + dj * dj);
                                    if (d < dist_q4[ny * 64 + nx])
                                        dist_q4[ny * 64 + nx] = DIST_W'(d);
                                end
                            end
                        end
                    end else if (occ < 10) begin
                        cls[idx] = CLS_FREE;
                    end else begin
                        cls[idx] = CLS_UNKNOWN;
                        dist_q4[idx] = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                $error("unexpected result: distance %0d class %0d",
                       got.obstacle_distance, got.cell_class);
                errors++;
                return;
            end
            want = due_results.pop_front();
            n_checked++;
            if (got.obstacle_distance !== want.obstacle_distance) begin
                $error("obstacle_distance: expected %0d, got %0d",
                       want.obstacle_distance, got.obstacle_distance);
                errors++;
            end
            if (got.cell_class !== want.cell_class) begin
                $error("cell_class: expected %0d, got %0d",
                       want.cell_class, got.cell_class);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_scoreboard sb;
    bit             idle_on;
    int             stall_cycles;
    int             last_x, last_y;

    obstacle_distance_grid i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Check each result transaction; watch for a stalled run
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_item);
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIM) begin
            $display("timeout after %0d idle cycles", STALL_LIM);
            $display("FAIL obstacle_distance_grid");
            $finish;
        end
    end

    // Receiver back-pressure in bursts
    initial begin
        i_ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_ready <= 1'b1;
            end
            repeat ($urandom_range(0, 15)) @(posedge i_clk);
        end
    end

    task automatic cfg_write(input logic [7:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_RADIUS;
        pwdata  <= {24'd0, value};
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.radius = 32'(value);
    endtask

    // Called just after a rising edge; returns at the edge that accepts the item
    task automatic send_item(input t_in_item it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(it);
    endtask

    task automatic send(input logic [1:0] kind, input int x, input int y,
                        input int green);
        t_in_item it;
        it.kind = kind;
        it.cell_x = COORD_W'(x);
        it.cell_y = COORD_W'(y);
        it.green_level = GREEN_W'(green);
        send_item(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic int near_coord(input int c);
        int v;
        v = c + $urandom_range(0, 18) - 9;
        return (v < 0) ? 0 : (v > 63) ? 63 : v;
    endfunction

    task automatic random_item();
        int pick, occ_pct, x, y, g;
        pick = $urandom_range(0, 999);
        occ_pct = (sb.reach() >= 5) ? 3 : 20;
        if ($urandom_range(0, 1)) begin
            x = near_coord(last_x);
            y = near_coord(last_y);
        end else begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
        end
        if (pick < 6) begin
            send(KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 255));
        end else if (pick < 20) begin
            send(KIND_UNUSED, x, y, $urandom_range(0, 255));
        end else if (pick < 450) begin
            send(KIND_QUERY, x, y, $urandom_range(0, 255));
        end else begin
            g = $urandom_range(0, 99);
            if (g < occ_pct) begin
                g = $urandom_range(0, 25);
                last_x = x;
                last_y = y;
            end else if (g < 60) begin
                g = $urandom_range(233, 255);
            end else if (g < 85) begin
                g = $urandom_range(26, 232);
            end else begin
                g = $urandom_range(24, 255);
            end
            send(KIND_LOAD, x, y, g);
        end
    endtask

    initial begin
        logic [7:0] radii [8] = '{8'd16, 8'd0, 8'd128, 8'd1, 8'd255, 8'd200,
                                  8'd33, 8'd64};
        sb = new();
        idle_on = 1'b1;
        last_x = 32;
        last_y = 32;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset contents, corners, class thresholds, unused kind, clear
        send(KIND_QUERY, 0, 0, 0);
        send(KIND_QUERY, 63, 63, 255);
        drain();
        cfg_write(8'd64);
        send(KIND_LOAD, 0, 0, 0);
        send(KIND_QUERY, 0, 0, 0);
        send(KIND_QUERY, 4, 4, 0);
        send(KIND_QUERY, 1, 3, 0);
        send(KIND_LOAD, 63, 63, 25);
        send(KIND_QUERY, 60, 63, 0);
        send(KIND_LOAD, 63, 0, 26);
        send(KIND_LOAD, 0, 63, 232);
        send(KIND_LOAD, 10, 10, 233);
        send(KIND_LOAD, 11, 10, 255);
        send(KIND_LOAD, 63, 60, 128);
        send(KIND_QUERY, 63, 0, 0);
        send(KIND_QUERY, 0, 63, 0);
        send(KIND_QUERY, 10, 10, 0);
        send(KIND_QUERY, 11, 10, 0);
        send(KIND_QUERY, 63, 60, 0);
        send(KIND_UNUSED, 5, 5, 0);
        send(KIND_QUERY, 5, 5, 0);
        send(KIND_CLEAR, 42, 21, 170);
        send(KIND_QUERY, 0, 0, 0);
        send(KIND_QUERY, 63, 63, 0);
        drain();

        foreach (radii[p]) begin
            if (p == 7) idle_on = 1'b0;
            cfg_write(radii[p]);
            repeat (ITEMS_PER_PHASE) random_item();
            send(KIND_QUERY, last_x, last_y, 0);
            drain();
        end

        i_valid <= 1'b0;
        repeat (100) @(posedge i_clk);
        if (sb.due_results.size() != 0) begin
            $error("%0d results never arrived", sb.due_results.size());
            sb.errors++;
        end
        $display("covered %0d loads, %0d queries, %0d clears over 9 radius settings",
                 sb.n_loads, sb.n_queries, sb.n_clears);
        $display("checked %0d results, %0d errors", sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS obstacle_distance_grid");
        else
            $display("FAIL obstacle_distance_grid");
        $finish;
    end
endmodule

// ----- obstacle_distance_grid.f -----
design/odg_pkg.sv
design/odg_front.sv
design/odg_queue.sv
design/odg_back.sv
design/obstacle_distance_grid.sv
dv/obstacle_distance_grid_tb.sv
